FILE: hw/rtl/msp_pkg.sv
// Shared types, constants and helpers for the monotone spline power map.
`default_nettype none
package msp_pkg;

	localparam int unsigned FRAC = 16;
	localparam int unsigned VAL_W = FRAC + 1;
	localparam int unsigned TAN_W = 32;
	localparam int unsigned TAN_FRAC = 16;
	localparam int unsigned NUM_KNOTS = 5;
	localparam int unsigned NUM_SEGS = 4;
	localparam int unsigned NUM_REGS = 7;
	localparam int unsigned IDX_W = 3;

	localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1 << FRAC);
	localparam logic [TAN_W-1:0] TAN_MAX = '1;

	localparam logic [IDX_W-1:0] REG_LOW_IN = 3'd0;
	localparam logic [IDX_W-1:0] REG_LOW_OUT = 3'd1;
	localparam logic [IDX_W-1:0] REG_MID_IN = 3'd2;
	localparam logic [IDX_W-1:0] REG_MID_OUT = 3'd3;
	localparam logic [IDX_W-1:0] REG_HIGH_IN = 3'd4;
	localparam logic [IDX_W-1:0] REG_HIGH_OUT = 3'd5;
	localparam logic [IDX_W-1:0] REG_SHELF = 3'd6;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [NUM_KNOTS-1:0][TAN_W-1:0] tan_vec_t;

	typedef struct packed {
		val_t low_in;
		val_t low_out;
		val_t mid_in;
		val_t mid_out;
		val_t high_in;
		val_t high_out;
		logic shelf;
	} knees_t;

	function automatic logic knees_valid(knees_t k);
		return (k.low_in < k.mid_in) && (k.mid_in < k.high_in) && (k.high_in <= VAL_ONE) &&
			(k.low_out <= k.mid_out) && (k.mid_out <= k.high_out) &&
			(k.high_out <= VAL_ONE);
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/msp_if.sv
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface msp_in_if;
	logic valid;
	logic ready;
	logic [msp_pkg::VAL_W-1:0] power_in;
	modport source (output valid, output power_in, input ready);
	modport sink (input valid, input power_in, output ready);
endinterface

interface msp_out_if;
	logic valid;
	logic ready;
	logic [msp_pkg::VAL_W-1:0] power_out;
	logic config_error;
	modport source (output valid, output power_out, output config_error, input ready);
	modport sink (input valid, input power_out, input config_error, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/msp_tangent_unit.sv
// Sequencer that derives the knot tangents from the knees with a bit-serial divider.
`default_nettype none
module msp_tangent_unit (
	input logic clk,
	input logic arst_n,
	input msp_pkg::knees_t knees,
	input logic start,
	output msp_pkg::tan_vec_t tangents,
	output logic busy
);

	localparam int unsigned VW = msp_pkg::VAL_W;
	localparam int unsigned TW = msp_pkg::TAN_W;
	localparam int unsigned DIVIDEND_W = VW + msp_pkg::TAN_FRAC;
	localparam int unsigned BIT_W = $clog2(DIVIDEND_W);
	localparam int unsigned DYI_W = $clog2(VW);
	localparam int unsigned NS = msp_pkg::NUM_SEGS;
	localparam int unsigned NK = msp_pkg::NUM_KNOTS;

	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_DIV, ST_MEAN, ST_LIMIT} state_t;

	state_t state_q;
	logic [1:0] seg_q;
	logic [BIT_W-1:0] bit_q;
	logic [VW-1:0] rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [NS-1:0][TW-1:0] sec_q;
	logic [NK-1:0][TW-1:0] m_q;
	logic [NS-1:0] skip_q;
	msp_pkg::tan_vec_t tan_q;

	logic [1:0] last_seg;
	logic [2:0] j0, j1;
	logic [VW-1:0] x0, x1, y0, y1, dx, dy;
	logic [BIT_W-1:0] dy_off;
	logic [DYI_W-1:0] dy_idx;
	logic dbit, ge;
	logic [VW:0] cand;
	logic [VW-1:0] rem_n;
	logic [DIVIDEND_W-1:0] quo_n;
	logic [TW-1:0] sec_val;
	logic [NK-1:0][TW-1:0] m_n, ml;
	logic [NS-1:0] skip_n;
	logic [NS-1:0][TW+1:0] lim3;
	msp_pkg::tan_vec_t tan_n;

	function automatic logic [VW-1:0] knot(msp_pkg::knees_t k, logic [2:0] j, logic sel_y);
		logic [VW-1:0] r;
		r = '0;
		if (k.shelf) begin
			case (j)
				3'd0: r = sel_y ? k.low_out : k.low_in;
				3'd1: r = sel_y ? k.mid_out : k.mid_in;
				default: r = sel_y ? k.high_out : k.high_in;
			endcase
		end else begin
			case (j)
				3'd0: r = '0;
				3'd1: r = sel_y ? k.low_out : k.low_in;
				3'd2: r = sel_y ? k.mid_out : k.mid_in;
				3'd3: r = sel_y ? k.high_out : k.high_in;
				default: r = msp_pkg::VAL_ONE;
			endcase
		end
		return r;
	endfunction

	function automatic logic [TW-1:0] mean2(logic [TW-1:0] a, logic [TW-1:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TW:1];
	endfunction

	assign last_seg = knees.shelf ? 2'd1 : 2'd3;
	assign j0 = {1'b0, seg_q};
	assign j1 = j0 + 3'd1;
	assign x0 = knot(knees, j0, 1'b0);
	assign x1 = knot(knees, j1, 1'b0);
	assign y0 = knot(knees, j0, 1'b1);
	assign y1 = knot(knees, j1, 1'b1);
	assign dx = x1 - x0;
	assign dy = y1 - y0;

	assign dy_off = bit_q - BIT_W'(msp_pkg::TAN_FRAC);
	assign dy_idx = dy_off[DYI_W-1:0];
	assign dbit = (bit_q >= BIT_W'(msp_pkg::TAN_FRAC)) ? dy[dy_idx] : 1'b0;
	assign cand = {rem_q, dbit};
	assign ge = cand >= {1'b0, dx};
	assign rem_n = ge ? VW'(cand - {1'b0, dx}) : cand[VW-1:0];
	assign quo_n = {quo_q[DIVIDEND_W-2:0], ge};

	always_comb begin
		if (dx == '0) begin
			sec_val = (dy == '0) ? '0 : msp_pkg::TAN_MAX;
		end else if (quo_n[DIVIDEND_W-1]) begin
			sec_val = msp_pkg::TAN_MAX;
		end else begin
			sec_val = quo_n[TW-1:0];
		end
	end

	always_comb begin
		m_n = '0;
		skip_n = '0;
		m_n[0] = sec_q[0];
		if (knees.shelf) begin
			m_n[1] = mean2(sec_q[0], sec_q[1]);
			m_n[2] = sec_q[1];
		end else begin
			for (int i = 1; i < NS; i++) begin
				m_n[i] = mean2(sec_q[i-1], sec_q[i]);
			end
			m_n[NK-1] = sec_q[NS-1];
		end
		for (int i = 0; i < NS; i++) begin
			if (i <= int'(last_seg) && sec_q[i] == '0) begin
				m_n[i] = '0;
				m_n[i+1] = '0;
				skip_n[i] = 1'b1;
			end
		end
	end

	always_comb begin
		ml = m_q;
		for (int i = 0; i < NS; i++) begin
			lim3[i] = ({2'b00, sec_q[i]} << 1) + {2'b00, sec_q[i]};
			if (i <= int'(last_seg) && !skip_q[i]) begin
				if ({2'b00, m_q[i]} > lim3[i] || {2'b00, m_q[i+1]} > lim3[i]) begin
					ml[i] = (lim3[i][TW+1:TW] != 2'b00) ? msp_pkg::TAN_MAX : lim3[i][TW-1:0];
				end
			end
		end
		if (knees.shelf) begin
			tan_n = '0;
			tan_n[1] = ml[0];
			tan_n[2] = ml[1];
			tan_n[3] = ml[2];
		end else begin
			tan_n = ml;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PREP;
			seg_q <= '0;
			bit_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			sec_q <= '0;
			m_q <= '0;
			skip_q <= '0;
			tan_q <= '0;
		end else if (start) begin
			state_q <= ST_PREP;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_PREP: begin
					if (!msp_pkg::knees_valid(knees)) begin
						tan_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						seg_q <= '0;
						bit_q <= BIT_W'(DIVIDEND_W - 1);
						rem_q <= '0;
						quo_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						sec_q[seg_q] <= sec_val;
						if (seg_q == last_seg) begin
							state_q <= ST_MEAN;
						end else begin
							seg_q <= seg_q + 2'd1;
							bit_q <= BIT_W'(DIVIDEND_W - 1);
							rem_q <= '0;
							quo_q <= '0;
						end
					end else begin
						bit_q <= bit_q - BIT_W'(1);
						rem_q <= rem_n;
						quo_q <= quo_n;
					end
				end
				ST_MEAN: begin
					m_q <= m_n;
					skip_q <= skip_n;
					state_q <= ST_LIMIT;
				end
				ST_LIMIT: begin
					tan_q <= tan_n;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign tangents = tan_q;
	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

FILE: hw/rtl/msp_eval_pipe.sv
// Evaluation pipeline: segment select, pipelined divider, Hermite basis and sum.
`default_nettype none
module msp_eval_pipe (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_fire,
	input logic [msp_pkg::VAL_W-1:0] power_in,
	input msp_pkg::knees_t knees,
	input msp_pkg::tan_vec_t tangents,
	output logic res_valid,
	output logic [msp_pkg::VAL_W-1:0] res_power,
	output logic res_error
);

	localparam int unsigned VW = msp_pkg::VAL_W;
	localparam int unsigned TW = msp_pkg::TAN_W;
	localparam int unsigned FR = msp_pkg::FRAC;
	localparam int unsigned TF = msp_pkg::TAN_FRAC;
	localparam int unsigned DIV_STEPS = VW;
	localparam int unsigned SUM_W = TW + 4;
	localparam logic [VW:0] THREE_ONE = (VW+1)'(3 * (1 << FR));

	typedef struct packed {
		logic [VW-1:0] x, x0, y0, x1, y1;
		logic [TW-1:0] m0, m1;
		logic byp;
		logic [VW-1:0] byp_val;
		logic err;
	} seg_t;

	typedef struct packed {
		logic [VW-1:0] dx, y0, y1;
		logic [TW-1:0] m0, m1;
		logic byp;
		logic [VW-1:0] byp_val;
		logic err;
	} pay_t;

	typedef struct packed {
		pay_t pay;
		logic [VW-1:0] rem;
		logic [VW-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [VW-1:0] t, s, t2, ss;
		logic [TW-1:0] a0, a1;
		logic [VW-1:0] y0, y1;
		logic byp;
		logic [VW-1:0] byp_val;
		logic err;
	} e1_t;

	typedef struct packed {
		logic [VW:0] h01;
		logic [VW-1:0] h10, h11;
		logic [TW-1:0] a0, a1;
		logic [VW-1:0] y0, y1;
		logic byp;
		logic [VW-1:0] byp_val;
		logic err;
	} e2_t;

	typedef struct packed {
		logic [VW+1:0] ta;
		logic [TW:0] tb, tc;
		logic [VW-1:0] y0;
		logic neg;
		logic byp;
		logic [VW-1:0] byp_val;
		logic err;
	} e3_t;

	seg_t seg_n, seg_s1;
	pay_t pay_n, pay_s2;
	logic [VW-1:0] u_n, u_s2;
	div_t div_n [DIV_STEPS];
	div_t div_s [DIV_STEPS];
	logic dv_s [DIV_STEPS];
	e1_t e1_n, e1_s;
	e2_t e2_n, e2_s;
	e3_t e3_n, e3_s;
	logic v_s1, v_s2, v_e1, v_e2, v_e3;
	logic out_valid_q, out_err_q;
	logic [VW-1:0] out_power_q;

	logic [VW-1:0] xc;
	logic [VW-1:0] dx2, u0;
	logic zw;
	logic [2*VW-1:0] p_tt, p_ss, p_ts, p_t2s;
	logic [VW+TW-1:0] p_a0, p_a1, p_b, p_c;
	logic [VW:0] w3;
	logic [2*VW+1:0] p_h01;
	logic [2*VW:0] p_ta;
	logic [VW-1:0] dyabs;
	logic signed [SUM_W-1:0] vsum;
	logic [VW-1:0] clamp_val;

	// Stage 1: clamp the input and pick the segment.
	assign xc = (power_in > msp_pkg::VAL_ONE) ? msp_pkg::VAL_ONE : power_in;

	always_comb begin
		seg_n = '0;
		seg_n.x = xc;
		priority if (!msp_pkg::knees_valid(knees)) begin
			seg_n.byp = 1'b1;
			seg_n.byp_val = '0;
			seg_n.err = 1'b1;
		end else if (xc < knees.low_in) begin
			seg_n.byp = knees.shelf;
			seg_n.byp_val = knees.low_out;
			seg_n.x0 = '0;
			seg_n.y0 = '0;
			seg_n.x1 = knees.low_in;
			seg_n.y1 = knees.low_out;
			seg_n.m0 = tangents[0];
			seg_n.m1 = tangents[1];
		end else if (xc < knees.mid_in) begin
			seg_n.x0 = knees.low_in;
			seg_n.y0 = knees.low_out;
			seg_n.x1 = knees.mid_in;
			seg_n.y1 = knees.mid_out;
			seg_n.m0 = tangents[1];
			seg_n.m1 = tangents[2];
		end else if (xc < knees.high_in) begin
			seg_n.x0 = knees.mid_in;
			seg_n.y0 = knees.mid_out;
			seg_n.x1 = knees.high_in;
			seg_n.y1 = knees.high_out;
			seg_n.m0 = tangents[2];
			seg_n.m1 = tangents[3];
		end else begin
			seg_n.byp = knees.shelf;
			seg_n.byp_val = knees.high_out;
			seg_n.x0 = knees.high_in;
			seg_n.y0 = knees.high_out;
			seg_n.x1 = msp_pkg::VAL_ONE;
			seg_n.y1 = msp_pkg::VAL_ONE;
			seg_n.m0 = tangents[3];
			seg_n.m1 = tangents[4];
		end
	end

	// Stage 2: segment width and clamped offset into the segment.
	assign zw = seg_s1.x1 <= seg_s1.x0;
	assign dx2 = seg_s1.x1 - seg_s1.x0;
	assign u0 = (seg_s1.x > seg_s1.x0) ? (seg_s1.x - seg_s1.x0) : '0;
	assign u_n = (u0 > dx2) ? dx2 : u0;

	always_comb begin
		pay_n.dx = dx2;
		pay_n.y0 = seg_s1.y0;
		pay_n.y1 = seg_s1.y1;
		pay_n.m0 = seg_s1.m0;
		pay_n.m1 = seg_s1.m1;
		pay_n.byp = seg_s1.byp || zw;
		pay_n.byp_val = seg_s1.byp ? seg_s1.byp_val : seg_s1.y1;
		pay_n.err = seg_s1.err;
	end

	// Divider: one quotient bit per stage, offset never exceeds the width.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [VW:0] cand;
		pay_t src_pay;
		logic [VW-1:0] src_quo;
		logic ge;
		if (k == 0) begin : g_first
			assign cand = {1'b0, u_s2};
			assign src_pay = pay_s2;
			assign src_quo = '0;
		end else begin : g_next
			assign cand = {div_s[k-1].rem, 1'b0};
			assign src_pay = div_s[k-1].pay;
			assign src_quo = div_s[k-1].quo;
		end
		assign ge = cand >= {1'b0, src_pay.dx};
		assign div_n[k] = '{
			pay: src_pay,
			rem: ge ? VW'(cand - {1'b0, src_pay.dx}) : cand[VW-1:0],
			quo: {src_quo[VW-2:0], ge}
		};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en) begin
				if (k == 0) begin
					dv_s[k] <= v_s2;
				end else begin
					dv_s[k] <= dv_s[(k == 0) ? 0 : k-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= div_n[k];
			end
		end
	end

	// E1: squares and tangent terms.
	always_comb begin
		e1_n.t = div_s[DIV_STEPS-1].quo;
		e1_n.s = msp_pkg::VAL_ONE - e1_n.t;
		p_tt = {{VW{1'b0}}, e1_n.t} * {{VW{1'b0}}, e1_n.t};
		p_ss = {{VW{1'b0}}, e1_n.s} * {{VW{1'b0}}, e1_n.s};
		p_a0 = {{TW{1'b0}}, div_s[DIV_STEPS-1].pay.dx} * {{VW{1'b0}}, div_s[DIV_STEPS-1].pay.m0};
		p_a1 = {{TW{1'b0}}, div_s[DIV_STEPS-1].pay.dx} * {{VW{1'b0}}, div_s[DIV_STEPS-1].pay.m1};
		e1_n.t2 = p_tt[VW+FR-1:FR];
		e1_n.ss = p_ss[VW+FR-1:FR];
		e1_n.a0 = p_a0[TW+TF-1:TF];
		e1_n.a1 = p_a1[TW+TF-1:TF];
		e1_n.y0 = div_s[DIV_STEPS-1].pay.y0;
		e1_n.y1 = div_s[DIV_STEPS-1].pay.y1;
		e1_n.byp = div_s[DIV_STEPS-1].pay.byp;
		e1_n.byp_val = div_s[DIV_STEPS-1].pay.byp_val;
		e1_n.err = div_s[DIV_STEPS-1].pay.err;
	end

	// E2: Hermite basis values.
	always_comb begin
		w3 = THREE_ONE - {e1_s.t, 1'b0};
		p_h01 = {{(VW+1){1'b0}}, 1'b0, e1_s.t2} * {{(VW+1){1'b0}}, w3};
		p_ts = {{VW{1'b0}}, e1_s.t} * {{VW{1'b0}}, e1_s.ss};
		p_t2s = {{VW{1'b0}}, e1_s.t2} * {{VW{1'b0}}, e1_s.s};
		e2_n.h01 = p_h01[VW+FR:FR];
		e2_n.h10 = p_ts[VW+FR-1:FR];
		e2_n.h11 = p_t2s[VW+FR-1:FR];
		e2_n.a0 = e1_s.a0;
		e2_n.a1 = e1_s.a1;
		e2_n.y0 = e1_s.y0;
		e2_n.y1 = e1_s.y1;
		e2_n.byp = e1_s.byp;
		e2_n.byp_val = e1_s.byp_val;
		e2_n.err = e1_s.err;
	end

	// E3: weighted terms.
	always_comb begin
		e3_n.neg = e2_s.y1 < e2_s.y0;
		dyabs = e3_n.neg ? (e2_s.y0 - e2_s.y1) : (e2_s.y1 - e2_s.y0);
		p_ta = {{(VW+1){1'b0}}, dyabs} * {{VW{1'b0}}, e2_s.h01};
		p_b = {{TW{1'b0}}, e2_s.h10} * {{VW{1'b0}}, e2_s.a0};
		p_c = {{TW{1'b0}}, e2_s.h11} * {{VW{1'b0}}, e2_s.a1};
		e3_n.ta = p_ta[2*VW:FR];
		e3_n.tb = p_b[VW+TW-1:FR];
		e3_n.tc = p_c[VW+TW-1:FR];
		e3_n.y0 = e2_s.y0;
		e3_n.byp = e2_s.byp;
		e3_n.byp_val = e2_s.byp_val;
		e3_n.err = e2_s.err;
	end

	// Final sum and clamp into the output register.
	always_comb begin
		vsum = $signed({{(SUM_W-VW){1'b0}}, e3_s.y0});
		if (e3_s.neg) begin
			vsum = vsum - $signed({{(SUM_W-VW-2){1'b0}}, e3_s.ta});
		end else begin
			vsum = vsum + $signed({{(SUM_W-VW-2){1'b0}}, e3_s.ta});
		end
		vsum = vsum + $signed({{(SUM_W-TW-1){1'b0}}, e3_s.tb});
		vsum = vsum - $signed({{(SUM_W-TW-1){1'b0}}, e3_s.tc});
		if (vsum < 0) begin
			clamp_val = '0;
		end else if (vsum > $signed({{(SUM_W-VW){1'b0}}, msp_pkg::VAL_ONE})) begin
			clamp_val = msp_pkg::VAL_ONE;
		end else begin
			clamp_val = vsum[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			v_e3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_fire;
			v_s2 <= v_s1;
			v_e1 <= dv_s[DIV_STEPS-1];
			v_e2 <= v_e1;
			v_e3 <= v_e2;
			out_valid_q <= v_e3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= seg_n;
			pay_s2 <= pay_n;
			u_s2 <= u_n;
			e1_s <= e1_n;
			e2_s <= e2_n;
			e3_s <= e3_n;
			out_power_q <= e3_s.byp ? e3_s.byp_val : clamp_val;
			out_err_q <= e3_s.err;
		end
	end

	assign res_valid = out_valid_q;
	assign res_power = out_power_q;
	assign res_error = out_err_q;

endmodule
`default_nettype wire

FILE: hw/rtl/monotone_spline_power_map_unit.sv
// Top level of the monotone spline power map: registers, tangent sequencer and pipeline.
`default_nettype none
// Maps power_in to power_out along a monotone cubic Hermite curve through three knees.
// One item enters per cycle and its result passes two selection stages, a 17-stage
// divider for the segment position, three multiply stages and the output register;
// a stalled output holds the whole pipeline. After reset and after every register
// write the tangent sequencer recomputes the knot tangents with a bit-serial divider,
// one secant after another: two with the shelf on, four with it off, none when the
// knees are out of order. Input items are not accepted while it runs.
module monotone_spline_power_map_unit (
	input logic clk,
	input logic arst_n,
	msp_in_if.sink in_ch,
	msp_out_if.source out_ch,
	input logic cfg_we,
	input logic [msp_pkg::IDX_W-1:0] cfg_index,
	input logic [msp_pkg::VAL_W-1:0] cfg_data
);

	msp_pkg::knees_t knees_q;
	msp_pkg::tan_vec_t tangents;
	logic tan_busy, tan_start, en, in_fire;
	logic res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knees_q.low_in <= '0;
			knees_q.low_out <= '0;
			knees_q.mid_in <= msp_pkg::VAL_W'(1 << (msp_pkg::FRAC - 1));
			knees_q.mid_out <= msp_pkg::VAL_W'(1 << (msp_pkg::FRAC - 1));
			knees_q.high_in <= msp_pkg::VAL_ONE;
			knees_q.high_out <= msp_pkg::VAL_ONE;
			knees_q.shelf <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				msp_pkg::REG_LOW_IN: knees_q.low_in <= cfg_data;
				msp_pkg::REG_LOW_OUT: knees_q.low_out <= cfg_data;
				msp_pkg::REG_MID_IN: knees_q.mid_in <= cfg_data;
				msp_pkg::REG_MID_OUT: knees_q.mid_out <= cfg_data;
				msp_pkg::REG_HIGH_IN: knees_q.high_in <= cfg_data;
				msp_pkg::REG_HIGH_OUT: knees_q.high_out <= cfg_data;
				msp_pkg::REG_SHELF: knees_q.shelf <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign tan_start = cfg_we && (cfg_index < msp_pkg::IDX_W'(msp_pkg::NUM_REGS));

	msp_tangent_unit u_tangent (
		.clk(clk),
		.arst_n(arst_n),
		.knees(knees_q),
		.start(tan_start),
		.tangents(tangents),
		.busy(tan_busy)
	);

	assign en = !res_valid || out_ch.ready;
	assign in_ch.ready = en && !tan_busy && !cfg_we;
	assign in_fire = in_ch.valid && in_ch.ready;

	msp_eval_pipe u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_fire(in_fire),
		.power_in(in_ch.power_in),
		.knees(knees_q),
		.tangents(tangents),
		.res_valid(res_valid),
		.res_power(out_ch.power_out),
		.res_error(out_ch.config_error)
	);

	assign out_ch.valid = res_valid;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.config_error |-> out_ch.power_out == '0)
		else $error("error result with nonzero level");
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		tan_busy |-> !in_ch.ready)
		else $error("input taken while tangents are recomputed");
	a_write_recalc: assert property (@(posedge clk) disable iff (!arst_n)
		tan_start |=> tan_busy)
		else $error("register write did not start a tangent update");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.power_out <= msp_pkg::VAL_ONE)
		else $error("result above full scale");
`endif

endmodule
`default_nettype wire
